@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define NRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// expr must hold after cond (non-overlapping implication)
`define NRE_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) else $error(msg);

`endif

@@ design/nre_pkg.sv @@
// ----------------------------------------------------------------------------
// nre_pkg
// shared constants and types of the nibble run-length encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nre_pkg;

    localparam int WindowDepthDef = 32;
    localparam int LOOKAHEAD      = 22;   // pixels buffered before a group is decided
    localparam int PIX_W          = 4;
    localparam int TDATA_W        = 8;
    localparam int MAX_GROUP      = 8;    // longest literal or repeat group
    localparam int LIT_BASE       = 16;   // literal header is LIT_BASE - count

    // one code nibble from the sequencer to the output register
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] nibble;
        logic             last;
    } t_code_out;

endpackage

@@ design/nre_window.sv @@
// ----------------------------------------------------------------------------
// nre_window
// circular pixel window: one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nre_window #(
    parameter int Depth = nre_pkg::WindowDepthDef
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(Depth)-1:0]     i_waddr,
    input  logic [nre_pkg::PIX_W-1:0]    i_wdata,
    input  logic [$clog2(Depth)-1:0]     i_raddr,
    output logic [nre_pkg::PIX_W-1:0]    o_rdata
);

    logic [nre_pkg::PIX_W-1:0] r_mem [Depth];
    logic [nre_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/nre_seq.sv @@
// ----------------------------------------------------------------------------
// nre_seq
// group decision and code emission sequencer around one pixel comparator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nre_seq #(
    parameter int Depth = nre_pkg::WindowDepthDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_valid,
    input  logic [nre_pkg::PIX_W-1:0]    i_pixel,
    input  logic                         i_final,
    output logic                         o_s_ready,
    output logic                         o_we,
    output logic [$clog2(Depth)-1:0]     o_waddr,
    output logic [nre_pkg::PIX_W-1:0]    o_wdata,
    output logic [$clog2(Depth)-1:0]     o_raddr,
    input  logic [nre_pkg::PIX_W-1:0]    i_rdata,
    input  logic                         i_out_free,
    output nre_pkg::t_code_out           o_code
);

    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam int SumW  = CntW + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_G_INIT  = 4'd1;
    localparam logic [3:0] S_G_FIRST = 4'd2;
    localparam logic [3:0] S_G_SCAN  = 4'd3;
    localparam logic [3:0] S_G_DEC   = 4'd4;
    localparam logic [3:0] S_E_HDR   = 4'd5;
    localparam logic [3:0] S_E_ADDR  = 4'd6;
    localparam logic [3:0] S_E_DATA  = 4'd7;
    localparam logic [3:0] S_UPD     = 4'd8;

    function automatic logic [AddrW-1:0] wrap(input logic [SumW-1:0] s);
        if (s >= SumW'(Depth)) begin
            return AddrW'(s - SumW'(Depth));
        end
        return AddrW'(s);
    endfunction

    // control
    logic [3:0]       r_state, n_state;
    logic [AddrW-1:0] r_head, n_head;
    logic [CntW-1:0]  r_count, n_count;
    logic             r_final, n_final;
    // working values of one group decision
    logic [CntW-1:0]  r_pos, n_pos;
    logic [3:0]       r_k, n_k;
    logic [3:0]       r_prev, n_prev;
    logic             r_same_done, n_same_done;
    logic             r_dif_done, n_dif_done;
    logic [3:0]       r_same_len, n_same_len;
    logic [3:0]       r_dif_len, n_dif_len;
    logic [4:0]       r_lit, n_lit;
    logic [4:0]       r_rep, n_rep;
    logic [3:0]       r_j, n_j;

    logic [CntW-1:0]  rem;
    logic [CntW:0]    roff;
    logic [3:0]       lit_c, rep_c, num, take;
    logic [CntW-1:0]  take_c;
    logic             use_lit;
    logic [3:0]       header;
    logic             eq, same_hit, dif_hit, same_dn, dif_dn, scan_end;
    logic [4:0]       lit_sum;
    logic [4:0]       rep_sum;
    logic [CntW-1:0]  pos_nx, cnt_nx;

    assign rem     = r_count - r_pos;
    assign lit_c   = (r_lit > 5'(nre_pkg::MAX_GROUP)) ? 4'(nre_pkg::MAX_GROUP) : r_lit[3:0];
    assign rep_c   = (r_rep > 5'(nre_pkg::MAX_GROUP)) ? 4'(nre_pkg::MAX_GROUP) : r_rep[3:0];
    assign use_lit = (lit_c != 4'd0);
    assign num     = use_lit ? lit_c : 4'd1;
    assign take    = use_lit ? lit_c : rep_c;
    assign take_c  = (CntW'(take) > r_count) ? r_count : CntW'(take);
    assign header  = use_lit ? 4'(5'(nre_pkg::LIT_BASE) - {1'b0, lit_c}) : 4'(rep_c - 4'd1);

    // read offset from the window head
    always_comb begin
        case (r_state)
            S_G_FIRST:           roff = (CntW+1)'(r_pos) + (CntW+1)'(1);
            S_G_SCAN:            roff = (CntW+1)'(r_pos) + (CntW+1)'(r_k) + (CntW+1)'(1);
            S_E_ADDR, S_E_DATA:  roff = (CntW+1)'(r_j);
            default:             roff = (CntW+1)'(r_pos);
        endcase
    end
    assign o_raddr = wrap(SumW'(r_head) + SumW'(roff));

    // the shared comparator and scan bookkeeping
    assign eq       = (r_prev == i_rdata);
    assign same_hit = !r_same_done && !eq && (r_k <= 4'd7);
    assign dif_hit  = !r_dif_done && eq;
    assign same_dn  = r_same_done | same_hit;
    assign dif_dn   = r_dif_done | dif_hit;
    assign scan_end = (r_k == 4'd8) || (CntW'(r_k) == rem - CntW'(1)) || (same_dn && dif_dn);

    assign lit_sum = r_lit + 5'(r_dif_len) + r_rep;
    assign rep_sum = r_rep + 5'd2;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_final     = r_final;
        n_pos       = r_pos;
        n_k         = r_k;
        n_prev      = r_prev;
        n_same_done = r_same_done;
        n_dif_done  = r_dif_done;
        n_same_len  = r_same_len;
        n_dif_len   = r_dif_len;
        n_lit       = r_lit;
        n_rep       = r_rep;
        n_j         = r_j;
        o_s_ready   = 1'b0;
        o_we        = 1'b0;
        o_waddr     = wrap(SumW'(r_head) + SumW'(r_count));
        o_wdata     = i_pixel;
        o_code      = '0;
        pos_nx      = r_pos;
        cnt_nx      = r_count - take_c;

        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_we    = (r_count < CntW'(Depth));
                    n_count = r_count + CntW'(o_we);
                    n_final = i_final;
                    if (i_final || (n_count >= CntW'(nre_pkg::LOOKAHEAD))) begin
                        n_pos   = '0;
                        n_lit   = '0;
                        n_rep   = '0;
                        n_state = S_G_INIT;
                    end
                end
            end
            S_G_INIT: begin
                n_state = S_G_FIRST;
            end
            S_G_FIRST: begin
                n_prev      = i_rdata;
                n_k         = 4'd1;
                n_same_done = 1'b0;
                n_dif_done  = 1'b0;
                if (rem == CntW'(1)) begin
                    n_same_len = 4'd1;
                    n_dif_len  = 4'd1;
                    n_state    = S_G_DEC;
                end else begin
                    n_state = S_G_SCAN;
                end
            end
            S_G_SCAN: begin
                n_same_done = same_dn;
                n_dif_done  = dif_dn;
                if (same_hit) begin
                    n_same_len = r_k;
                end else if (scan_end && !r_same_done) begin
                    n_same_len = (rem > CntW'(8)) ? 4'd8 : 4'(rem);
                end
                if (dif_hit) begin
                    n_dif_len = r_k - 4'd1;
                end else if (scan_end && !r_dif_done) begin
                    n_dif_len = (rem > CntW'(9)) ? 4'd9 : 4'(rem);
                end
                if (scan_end) begin
                    n_state = S_G_DEC;
                end else begin
                    n_k    = r_k + 4'd1;
                    n_prev = i_rdata;
                end
            end
            S_G_DEC: begin
                if (r_same_len > 4'd2) begin
                    n_rep   = 5'(r_same_len);
                    n_state = S_E_HDR;
                end else if (r_same_len == 4'd2) begin
                    pos_nx  = r_pos + CntW'(2);
                    n_rep   = rep_sum;
                    n_pos   = pos_nx;
                    if ((rep_sum > 5'd6) || (r_lit == 5'd0) || (pos_nx >= r_count)) begin
                        n_state = S_E_HDR;
                    end else begin
                        n_state = S_G_INIT;
                    end
                end else begin
                    pos_nx = r_pos + CntW'(r_dif_len);
                    n_lit  = lit_sum;
                    n_rep  = '0;
                    n_pos  = pos_nx;
                    if ((lit_sum > 5'd7) || (pos_nx >= r_count)) begin
                        n_state = S_E_HDR;
                    end else begin
                        n_state = S_G_INIT;
                    end
                end
            end
            S_E_HDR: begin
                if (i_out_free) begin
                    o_code.valid  = 1'b1;
                    o_code.nibble = header;
                    n_j           = '0;
                    n_state       = S_E_ADDR;
                end
            end
            S_E_ADDR: begin
                n_state = S_E_DATA;
            end
            S_E_DATA: begin
                if (i_out_free) begin
                    o_code.valid  = 1'b1;
                    o_code.nibble = i_rdata;
                    o_code.last   = r_final && (r_j == num - 4'd1) && (take_c == r_count);
                    n_j           = r_j + 4'd1;
                    n_state       = (r_j == num - 4'd1) ? S_UPD : S_E_ADDR;
                end
            end
            S_UPD: begin
                n_head  = wrap(SumW'(r_head) + SumW'(take_c));
                n_count = cnt_nx;
                n_pos   = '0;
                n_lit   = '0;
                n_rep   = '0;
                if (r_final) begin
                    if (cnt_nx == '0) begin
                        n_head  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_G_INIT;
                    end
                end else if (cnt_nx >= CntW'(nre_pkg::LOOKAHEAD)) begin
                    n_state = S_G_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_final <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_k         <= n_k;
        r_prev      <= n_prev;
        r_same_done <= n_same_done;
        r_dif_done  <= n_dif_done;
        r_same_len  <= n_same_len;
        r_dif_len   <= n_dif_len;
        r_lit       <= n_lit;
        r_rep       <= n_rep;
        r_j         <= n_j;
    end

    `NRE_ASSERT(a_count_bound, r_count <= CntW'(nre_pkg::LOOKAHEAD), "window count too large")
    `NRE_ASSERT(a_emit_free, o_code.valid |-> i_out_free, "code emitted into a full output")
    `NRE_ASSERT(a_scan_range, (r_state == S_G_SCAN) |-> ((r_pos + CntW'(r_k)) < r_count), "scan ran past the window")
    `NRE_ASSERT_NEXT(a_last_update, o_code.valid && o_code.last, r_state == S_UPD, "last code not followed by update")

endmodule

@@ design/nibble_rle_encoder_top.sv @@
// ----------------------------------------------------------------------------
// nibble_rle_encoder_top
// streaming 4-bit run-length encoder for glyph pixels
// ----------------------------------------------------------------------------
// Pixels enter one per transfer and collect in a circular window. Once 22
// pixels are held, or when the transfer carrying tlast arrives, the sequencer
// decides groups at the window head and sends out 4-bit codes: a literal of
// n pixels (1..8) as 16-n then the pixels, a repeat of n equal pixels (2..8)
// as n-1 then the value; output tlast marks the last code of a bitmap. A pixel
// that makes no group is taken while the sequencer is idle. A group decision
// walks the window with one comparator: a scan pass sets up the read, takes
// the first pixel, compares pixels one by one (up to 8 per pass) and decides;
// emission then sends the header, reads each pixel back from the window
// memory in an address and a data step and updates the window. After a
// triggering pixel tready stays low through this work, and longer while the
// output is stalled. A flush repeats this until the window is empty.
`timescale 1ns / 1ps

module nibble_rle_encoder_top #(
    parameter int WINDOW_DEPTH = nre_pkg::WindowDepthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [nre_pkg::TDATA_W-1:0]   i_s_tdata,   // [3:0] pixel
    input  logic                          i_s_tlast,   // final pixel of bitmap
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [nre_pkg::TDATA_W-1:0]   o_m_tdata,   // [3:0] code nibble
    output logic                          o_m_tlast    // final code of bitmap
);

    localparam int AddrW = $clog2(WINDOW_DEPTH);

    logic                        we;
    logic [AddrW-1:0]            waddr, raddr;
    logic [nre_pkg::PIX_W-1:0]   wdata, rdata;
    logic                        out_free;
    nre_pkg::t_code_out          code;

    // output register
    logic                        r_m_valid;
    logic [nre_pkg::PIX_W-1:0]   r_m_nibble;
    logic                        r_m_last;

    // a new code may enter when the register is empty or draining
    assign out_free = !r_m_valid || i_m_tready;

    nre_window #(.Depth(WINDOW_DEPTH)) u_window (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    nre_seq #(.Depth(WINDOW_DEPTH)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_tvalid),
        .i_pixel    (i_s_tdata[nre_pkg::PIX_W-1:0]),
        .i_final    (i_s_tlast),
        .o_s_ready  (o_s_tready),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .i_out_free (out_free),
        .o_code     (code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (code.valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (code.valid) begin
            r_m_nibble <= code.nibble;
            r_m_last   <= code.last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(nre_pkg::TDATA_W - nre_pkg::PIX_W){1'b0}}, r_m_nibble};
    assign o_m_tlast  = r_m_last;

endmodule
